// ----- hw/rtl/m4inv_pkg.sv -----
// ----------------------------------------------------------------------------
// m4inv_pkg
// shared types and constants of the 4x4 matrix inverse
// ----------------------------------------------------------------------------
package m4inv_pkg;

  localparam int unsigned ElemW = 12;
  localparam int unsigned CofW  = 40;
  localparam int unsigned DetW  = 53;
  localparam int unsigned OutW  = 32;

  typedef struct packed {
    logic signed [ElemW-1:0] element;
    logic                    restart;
  } in_item_t;

  typedef struct packed {
    logic signed [OutW-1:0] inv_element;
    logic                   singular;
    logic                   last;
  } out_item_t;

  // front to back: matrix queue status and read data
  typedef struct packed {
    logic                    avail;
    logic signed [ElemW-1:0] rd_data;
  } fr2bk_t;

  // back to front: read address and release of the oldest matrix
  typedef struct packed {
    logic [3:0] rd_addr;
    logic       pop;
  } bk2fr_t;

endpackage

// ----- hw/rtl/m4inv_front.sv -----
// ----------------------------------------------------------------------------
// m4inv_front
// element loader and two-matrix queue with a registered read port
// ----------------------------------------------------------------------------
module m4inv_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  m4inv_pkg::in_item_t in_item_i,
  input  m4inv_pkg::bk2fr_t   bk_i,
  output m4inv_pkg::fr2bk_t   fr_o
);

  logic signed [m4inv_pkg::ElemW-1:0] mem [32];
  logic signed [m4inv_pkg::ElemW-1:0] rd_q;
  logic [3:0] count_q, count_d;
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] level_q, level_d;
  logic       accept, push;
  logic [3:0] idx;

  assign in_stall_o = (level_q == 2'd2);
  assign accept     = in_valid_i && !in_stall_o;
  assign idx        = in_item_i.restart ? 4'd0 : count_q;
  assign push       = accept && (idx == 4'd15);

  always_comb begin
    count_d  = count_q;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (accept) begin
      count_d = idx + 4'd1;
    end
    if (push) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (bk_i.pop) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push && !bk_i.pop) begin
      level_d = level_q + 2'd1;
    end else if (!push && bk_i.pop) begin
      level_d = level_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      level_q  <= '0;
    end else begin
      count_q  <= count_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem[{wr_ptr_q, idx}] <= in_item_i.element;
    end
    rd_q <= mem[{rd_ptr_q, bk_i.rd_addr}];
  end

  assign fr_o.avail   = (level_q != 2'd0);
  assign fr_o.rd_data = rd_q;

endmodule

// ----- hw/rtl/m4inv_back.sv -----
// ----------------------------------------------------------------------------
// m4inv_back
// cofactor sequencer on one shared multiplier, determinant, serial divider
// ----------------------------------------------------------------------------
module m4inv_back #(
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  m4inv_pkg::fr2bk_t    fr_i,
  output m4inv_pkg::bk2fr_t    bk_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output m4inv_pkg::out_item_t out_item_o
);

  localparam int unsigned NumW = m4inv_pkg::CofW + FRACTION_BITS + 16;
  localparam int unsigned QW   = 33;
  localparam int unsigned RemW = 54;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_COF    = 3'd1;
  localparam logic [2:0] ST_DIV_RD = 3'd2;
  localparam logic [2:0] ST_DIV_LD = 3'd3;
  localparam logic [2:0] ST_DIV_IT = 3'd4;
  localparam logic [2:0] ST_OUT    = 3'd5;

  localparam logic signed [31:0] SatMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SatMin = 32'sh8000_0000;

  logic [2:0] state_q, state_d;
  logic [3:0] i_q, i_d;
  logic [1:0] term_q, term_d;
  logic [2:0] step_q, step_d;
  logic [3:0] o_q, o_d;
  logic [5:0] bit_q, bit_d;

  logic signed [11:0] h_q, h_d;
  logic signed [23:0] t_q, t_d;
  logic signed [51:0] p_q, p_d;
  logic signed [39:0] acc_q, acc_d;
  logic signed [52:0] det_q, det_d;

  logic signed [39:0] cof_mem [16];
  logic signed [39:0] cof_rd_q;
  logic               cof_we;
  logic signed [39:0] cof_wd;

  logic [RemW-1:0] rem_q, rem_d;
  logic [QW-1:0]   low_q, low_d;
  logic [QW-1:0]   quo_q, quo_d;
  logic            neg_q, neg_d;
  logic            ovf_q, ovf_d;

  logic               out_valid_q, out_valid_d;
  m4inv_pkg::out_item_t out_q, out_d;

  // operand addressing
  logic [1:0] dr, dc, ca, cb, ra, rb, rz, cx;
  logic [3:0] addr;
  always_comb begin
    dr = i_q[1:0];
    dc = i_q[3:2];
    case (term_q)
      2'd0:    begin ca = 2'd1; cb = 2'd2; end
      2'd1:    begin ca = 2'd0; cb = 2'd2; end
      default: begin ca = 2'd0; cb = 2'd1; end
    endcase
    rz = (2'd0 < dr) ? 2'd0 : 2'd1;
    ra = (2'd1 < dr) ? 2'd1 : 2'd2;
    rb = (2'd2 < dr) ? 2'd2 : 2'd3;
    case (step_q)
      3'd0:    cx = ca;
      3'd1:    cx = cb;
      3'd2:    cx = cb;
      3'd3:    cx = ca;
      default: cx = term_q;
    endcase
    cx = (cx < dc) ? cx : cx + 2'd1;
    case (step_q)
      3'd0:    addr = {ra, cx};
      3'd1:    addr = {rb, cx};
      3'd2:    addr = {ra, cx};
      3'd3:    addr = {rb, cx};
      default: addr = {rz, cx};
    endcase
    if (term_q == 2'd3) begin
      addr = {2'b00, i_q[3:2]};
    end
  end

  // shared multiplier, second operand always the matrix read data
  logic signed [24:0] diff;
  logic signed [39:0] mul_a;
  logic signed [51:0] mul_p;
  assign diff = $signed({t_q[23], t_q}) - $signed({p_q[23], p_q[23:0]});
  always_comb begin
    if (term_q == 2'd3) begin
      mul_a = acc_q;
    end else if (step_q == 3'd5) begin
      mul_a = 40'(diff);
    end else begin
      mul_a = 40'(h_q);
    end
  end
  assign mul_p = mul_a * fr_i.rd_data;

  logic               tneg;
  logic signed [39:0] addv, acc_n;
  assign tneg  = (i_q[0] ^ i_q[2]) ^ (term_q == 2'd1);
  assign addv  = tneg ? -p_q[39:0] : p_q[39:0];
  assign acc_n = (term_q == 2'd0) ? addv : acc_q + addv;

  // divider datapath
  logic [39:0]      un;
  logic [52:0]      ud;
  logic [NumW-1:0]  num;
  logic [RemW-1:0]  top, rem_sh;
  logic             ge, sing;
  assign un     = cof_rd_q[39] ? 40'(-cof_rd_q) : 40'(cof_rd_q);
  assign ud     = det_q[52] ? 53'(-det_q) : 53'(det_q);
  assign num    = {un, {(FRACTION_BITS + 16){1'b0}}};
  assign top    = RemW'(num[NumW-1:QW]);
  assign rem_sh = {rem_q[RemW-2:0], low_q[QW-1]};
  assign ge     = rem_sh >= {1'b0, ud};
  assign sing   = (det_q == '0);

  logic signed [31:0] res;
  always_comb begin
    if (sing) begin
      res = '0;
    end else if (ovf_q) begin
      res = neg_q ? SatMin : SatMax;
    end else if (neg_q) begin
      res = (quo_q > 33'h0_8000_0000) ? SatMin : -$signed(quo_q[31:0]);
    end else begin
      res = (quo_q > 33'h0_7FFF_FFFF) ? SatMax : $signed(quo_q[31:0]);
    end
  end

  always_comb begin
    state_d      = state_q;
    i_d          = i_q;
    term_d       = term_q;
    step_d       = step_q;
    o_d          = o_q;
    bit_d        = bit_q;
    h_d          = h_q;
    t_d          = t_q;
    p_d          = p_q;
    acc_d        = acc_q;
    det_d        = det_q;
    rem_d        = rem_q;
    low_d        = low_q;
    quo_d        = quo_q;
    neg_d        = neg_q;
    ovf_d        = ovf_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;
    cof_we       = 1'b0;
    cof_wd       = acc_n;
    bk_o.rd_addr = addr;
    bk_o.pop     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (fr_i.avail) begin
          state_d = ST_COF;
          i_d     = '0;
          term_d  = '0;
          step_d  = '0;
          det_d   = '0;
        end
      end
      ST_COF: begin
        step_d = step_q + 3'd1;
        if (term_q == 2'd3) begin
          case (step_q)
            3'd1:    p_d = mul_p;
            3'd2:    det_d = det_q + 53'(p_q);
            default: ;
          endcase
        end else begin
          case (step_q)
            3'd1:    h_d = fr_i.rd_data;
            3'd2:    p_d = mul_p;
            3'd3:    begin h_d = fr_i.rd_data; t_d = p_q[23:0]; end
            3'd4:    p_d = mul_p;
            3'd5:    p_d = mul_p;
            3'd6:    acc_d = acc_n;
            default: ;
          endcase
        end
        if (term_q != 2'd3 && step_q == 3'd6) begin
          step_d = '0;
          if (term_q != 2'd2) begin
            term_d = term_q + 2'd1;
          end else begin
            cof_we = 1'b1;
            if (i_q[1:0] == 2'd0) begin
              term_d = 2'd3;
            end else begin
              term_d = 2'd0;
              i_d    = i_q + 4'd1;
              if (i_q == 4'd15) begin
                bk_o.pop = 1'b1;
                state_d  = ST_DIV_RD;
                o_d      = '0;
              end
            end
          end
        end else if (term_q == 2'd3 && step_q == 3'd2) begin
          step_d = '0;
          term_d = 2'd0;
          i_d    = i_q + 4'd1;
        end
      end
      ST_DIV_RD: begin
        state_d = ST_DIV_LD;
      end
      ST_DIV_LD: begin
        rem_d = top;
        low_d = num[QW-1:0];
        quo_d = '0;
        bit_d = '0;
        neg_d = cof_rd_q[39] ^ det_q[52];
        ovf_d = top >= {1'b0, ud};
        if (sing || (top >= {1'b0, ud})) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_DIV_IT;
        end
      end
      ST_DIV_IT: begin
        rem_d = ge ? rem_sh - {1'b0, ud} : rem_sh;
        low_d = {low_q[QW-2:0], 1'b0};
        quo_d = {quo_q[QW-2:0], ge};
        bit_d = bit_q + 6'd1;
        if (bit_q == 6'(QW - 1)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d       = 1'b1;
          out_d.inv_element = res;
          out_d.singular    = sing;
          out_d.last        = (o_q == 4'd15);
          o_d               = o_q + 4'd1;
          state_d           = (o_q == 4'd15) ? ST_IDLE : ST_DIV_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      term_q      <= '0;
      step_q      <= '0;
      o_q         <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
      det_q       <= '0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      term_q      <= term_d;
      step_q      <= step_d;
      o_q         <= o_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
      det_q       <= det_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q   <= h_d;
    t_q   <= t_d;
    p_q   <= p_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
    low_q <= low_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
    ovf_q <= ovf_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (cof_we) begin
      cof_mem[i_q] <= cof_wd;
    end
    cof_rd_q <= cof_mem[o_q];
  end

  assign out_valid_o  = out_valid_q;
  assign out_item_o   = out_q;

endmodule

// ----- hw/rtl/matrix4x4_inverse.sv -----
// ----------------------------------------------------------------------------
// matrix4x4_inverse
// 4x4 matrix inverse by adjugate and determinant, Q4.8 in, Q16.16 out
// ----------------------------------------------------------------------------
// channel  direction  handshake               payload
// in       input      in_valid_i / in_stall_o  in_item_i  (element, restart)
// out      output     out_valid_o / out_stall_i out_item_o (inv_element, singular, last)
//
// one element per cycle is taken while the two-matrix queue has room
// per matrix the back part works out the cofactors and the determinant
// (triple products on the shared multiplier), then each result in the
// bit-serial divider (33 quotient bits)
// reset clears the queue, the load count and the sequencer
// a stalled output holds the sequencer in its output step only
// ----------------------------------------------------------------------------
module matrix4x4_inverse #(
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  m4inv_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output m4inv_pkg::out_item_t out_item_o
);

  m4inv_pkg::fr2bk_t fr2bk;
  m4inv_pkg::bk2fr_t bk2fr;

  m4inv_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .bk_i       (bk2fr),
    .fr_o       (fr2bk)
  );

  m4inv_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fr_i        (fr2bk),
    .bk_o        (bk2fr),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- tb/matrix4x4_inverse_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix4x4_inverse_tb
// checks the 4x4 adjugate inverse against a predictor of its own; identity,
// zero, extreme, saturating and restart matrices come first, then random
// matrices, some with small values so that singular ones occur, plus broken
// partial loads; both sides idle at random and the output holds off once for
// a long stretch so that the input side fills and stalls
// ----------------------------------------------------------------------------
module matrix4x4_inverse_tb;

  localparam int unsigned FracBits = 8;

  class inverse_scoreboard;
    longint      matrix[16];
    int unsigned load_count;
    m4inv_pkg::out_item_t expected_q[$];
    int unsigned errors;
    int unsigned matrices;
    int unsigned singulars;
    int unsigned results;

    function new();
      load_count = 0;
      errors = 0;
      matrices = 0;
      singulars = 0;
      results = 0;
    endfunction

    function longint minor3(int dr, int dc);
      longint m[9];
      int     n;
      n = 0;
      for (int r = 0; r < 4; r++) begin
        if (r == dr) continue;
        for (int c = 0; c < 4; c++) begin
          if (c == dc) continue;
          m[n] = matrix[r*4+c];
          n++;
        end
      end
      return m[0]*(m[4]*m[8] - m[5]*m[7]) - m[1]*(m[3]*m[8] - m[5]*m[6])
           + m[2]*(m[3]*m[7] - m[4]*m[6]);
    endfunction

    function longint quotient_sat(longint num, longint den);
      bit                neg;
      longint unsigned   un;
      longint unsigned   ud;
      longint unsigned   q;
      neg = (num < 0) != (den < 0);
      un = (num < 0) ? -num : num;
      ud = (den < 0) ? -den : den;
      q = (un << (FracBits + 16)) / ud;
      if (neg) return (q > 64'h8000_0000) ? -64'sh8000_0000 : -longint'(q);
      return (q > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(q);
    endfunction

    function void note_element(m4inv_pkg::in_item_t it);
      longint    adj[16];
      longint    det;
      m4inv_pkg::out_item_t res;
      if (it.restart) load_count = 0;
      matrix[load_count] = longint'($signed(it.element));
      load_count++;
      if (load_count < 16) return;
      load_count = 0;
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++)
          adj[r*4+c] = ((r + c) % 2) ? -minor3(c, r) : minor3(c, r);
      det = 0;
      for (int k = 0; k < 4; k++) det += matrix[k] * adj[k*4];
      matrices++;
      if (det == 0) singulars++;
      for (int i = 0; i < 16; i++) begin
        res.inv_element = (det == 0) ? 32'sd0 : 32'(quotient_sat(adj[i], det));
        res.singular = (det == 0);
        res.last = (i == 15);
        expected_q.push_back(res);
      end
    endfunction

    function void check_result(m4inv_pkg::out_item_t got);
      m4inv_pkg::out_item_t exp_r;
      results++;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: inv_element %0d", got.inv_element);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.inv_element !== exp_r.inv_element) begin
        $error("inv_element expected %0d actual %0d", exp_r.inv_element, got.inv_element);
        errors++;
      end
      if (got.singular !== exp_r.singular) begin
        $error("singular expected %0b actual %0b", exp_r.singular, got.singular);
        errors++;
      end
      if (got.last !== exp_r.last) begin
        $error("last expected %0b actual %0b", exp_r.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  m4inv_pkg::in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  m4inv_pkg::out_item_t out_item_o;

  inverse_scoreboard sb = new();
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  always #2 clk_i = ~clk_i;

  matrix4x4_inverse #(.FRACTION_BITS(FracBits)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o
  );

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_item_o);
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (4000) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(0, 11)) @(negedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        if (!quiet) repeat ($urandom_range(0, 20)) @(negedge clk_i);
      end
    end
  end

  task automatic send_element(logic signed [11:0] value, logic first);
    m4inv_pkg::in_item_t it;
    int       gap;
    it.element = value;
    it.restart = first;
    @(negedge clk_i);
    gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_element(it);
  endtask

  task automatic send_matrix(logic signed [11:0] m[16]);
    for (int i = 0; i < 16; i++) send_element(m[i], i == 0);
  endtask

  task automatic send_random_matrix(int span);
    logic signed [11:0] m[16];
    for (int i = 0; i < 16; i++)
      m[i] = (span == 0) ? 12'($urandom) : 12'($signed($urandom_range(0, 2*span)) - span);
    send_matrix(m);
  endtask

  initial begin
    logic signed [11:0] m[16];
    int unsigned        timeout;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // identity, 1.0 on the diagonal
    foreach (m[i]) m[i] = (i % 5 == 0) ? 12'sd256 : 12'sd0;
    send_matrix(m);
    // zero matrix is singular
    foreach (m[i]) m[i] = 12'sd0;
    send_matrix(m);
    // extremes
    foreach (m[i]) m[i] = (i % 5 == 0) ? 12'sh800 : ((i % 2) ? 12'sh7FF : -12'sd1);
    send_matrix(m);
    // unit upper triangle with large superdiagonal, saturates both ways
    foreach (m[i]) m[i] = (i % 5 == 0) ? 12'sd1 : ((i % 5 == 1) ? 12'sh7FF : 12'sd0);
    send_matrix(m);
    // partial load dropped by a restart
    for (int i = 0; i < 7; i++) send_element(12'($urandom), i == 0);
    send_random_matrix(0);
    // no restart on the first element still loads a full matrix
    for (int i = 0; i < 16; i++) send_element(12'($urandom), 1'b0);

    hold_req = 1'b1;
    for (int n = 0; n < 22; n++) begin
      if (n == 17) quiet = 1'b1;
      case ($urandom_range(0, 5))
        0: send_random_matrix(2);
        1: for (int i = 0; i < $urandom_range(1, 15); i++)
             send_element(12'($urandom), $urandom_range(0, 3) == 0);
        default: send_random_matrix(0);
      endcase
    end
    send_random_matrix(1);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    timeout = 0;
    while (sb.expected_q.size() != 0 && timeout < 200000) begin
      @(posedge clk_i);
      timeout++;
    end
    repeat (1000) @(posedge clk_i);
    $display("covered %0d matrices (%0d singular), %0d results checked",
             sb.matrices, sb.singulars, sb.results);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("matrix4x4_inverse: match");
    end else begin
      $display("matrix4x4_inverse: mismatch");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("run timed out");
    $display("matrix4x4_inverse: mismatch");
    $finish;
  end

endmodule
